// ===== sv/nbpfa_pkg.sv =====
// Shared types and constants for the n-body pair force accumulator.
package nbpfa_pkg;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   localparam logic [1:0] CSR_COUNT = 2'd0;
   localparam logic [1:0] CSR_GRAV  = 2'd1;
   localparam logic [1:0] CSR_SOFT  = 2'd2;
   localparam logic [1:0] CSR_CAP   = 2'd3;

   localparam logic [6:0]  COUNT_RESET = 7'd64;
   localparam logic [31:0] GRAV_RESET  = 32'd18472126;
   localparam logic [15:0] SOFT_RESET  = 16'd100;
   localparam logic [39:0] CAP_RESET   = 40'd1082670000;

   typedef struct packed {
      logic               command;
      logic [5:0]         particle_index;
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic signed [47:0] pos_z;
      logic signed [47:0] vel_x;
      logic signed [47:0] vel_y;
      logic signed [47:0] vel_z;
      logic [15:0]        mass;
   } req_type;

   typedef struct packed {
      logic [5:0]         result_index;
      logic signed [47:0] rate_x;
      logic signed [47:0] rate_y;
      logic signed [47:0] rate_z;
      logic signed [39:0] force_x;
      logic signed [39:0] force_y;
      logic signed [39:0] force_z;
   } rsp_type;

   typedef struct packed {
      logic [47:0] pos_x;
      logic [47:0] pos_y;
      logic [47:0] pos_z;
      logic [47:0] vel_x;
      logic [47:0] vel_y;
      logic [47:0] vel_z;
      logic [15:0] mass;
   } entry_type;

endpackage

// ===== sv/nbody_pair_force_accumulator.sv =====
// Top level: particle store and sequenced pair-force evaluation.
//
//  channel  ports                        transfer
//  request  start, busy, req             start && !busy
//  result   rsp_valid, rsp               rsp_valid, one cycle, no stall
//  config   csr_we, csr_index, csr_wdata csr_we
//
// A load writes the particle memory on its transfer. An evaluate holds busy while it reads
// its own index and then each partner: a shared shift-add multiplier (one operand bit per
// cycle), a bit-pair square root and a restoring divider (per axis) run in turn. Short
// operands finish sooner.
// The particle memory has one read port with a registered output.
// Reset is synchronous and clears control state and registers only.
// The result strobe lasts one cycle; the receiver cannot stall.
module nbody_pair_force_accumulator
   import nbpfa_pkg::*;
#(
   parameter int MAX_PARTICLES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req,
   output logic        rsp_valid,
   output rsp_type     rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata
);

   localparam int AW  = $clog2(MAX_PARTICLES);
   localparam int JW  = (AW + 1 > 7) ? AW + 1 : 7;
   localparam int MW  = 160;
   localparam int SW  = 100;
   localparam int DW  = 152;
   localparam int VW  = 200;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_IRD  = 4'd1;
   localparam logic [3:0] ST_NEXT = 4'd2;
   localparam logic [3:0] ST_JRD  = 4'd3;
   localparam logic [3:0] ST_SQ   = 4'd4;
   localparam logic [3:0] ST_SQRT = 4'd5;
   localparam logic [3:0] ST_R2   = 4'd6;
   localparam logic [3:0] ST_R3   = 4'd7;
   localparam logic [3:0] ST_MM   = 4'd8;
   localparam logic [3:0] ST_GM   = 4'd9;
   localparam logic [3:0] ST_AXIS = 4'd10;
   localparam logic [3:0] ST_NUM  = 4'd11;
   localparam logic [3:0] ST_DIV  = 4'd12;
   localparam logic [3:0] ST_TERM = 4'd13;

   // configuration
   logic [6:0]  count_ff;
   logic [31:0] grav_ff;
   logic [15:0] soft_ff;
   logic [39:0] cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         grav_ff  <= GRAV_RESET;
         soft_ff  <= SOFT_RESET;
         cap_ff   <= CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COUNT: count_ff <= csr_wdata[6:0];
            CSR_GRAV:  grav_ff  <= csr_wdata[31:0];
            CSR_SOFT:  soft_ff  <= csr_wdata[15:0];
            CSR_CAP:   cap_ff   <= csr_wdata;
         endcase
      end
   end

   // state
   logic [3:0]        state_ff, state_in;
   logic [JW-1:0]     j_ff, j_in;
   logic [1:0]        k_ff, k_in;
   logic [5:0]        idx_ff, idx_in;
   logic [47:0]       pix_ff, piy_ff, piz_ff, pix_in, piy_in, piz_in;
   logic [47:0]       vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic [15:0]       mi_ff, mi_in, mj_ff, mj_in;
   logic [48:0]       d_ff [3];
   logic [48:0]       d_in [3];
   logic [48:0]       mag_ff [3];
   logic [48:0]       mag_in [3];
   logic [SW-1:0]     s_ff, s_in, op_ff, op_in, res_ff, res_in, one_ff, one_in;
   logic [49:0]       r_ff, r_in;
   logic [DW-1:0]     den_ff, den_in;
   logic [63:0]       gm_ff, gm_in;
   logic [MW-1:0]     mul_a_ff, mul_a_in, mul_p_ff, mul_p_in;
   logic [63:0]       mul_b_ff, mul_b_in;
   logic [VW-1:0]     rem_ff, rem_in, dsh_ff, dsh_in;
   logic [40:0]       q_ff, q_in;
   logic [5:0]        dcnt_ff, dcnt_in;
   logic signed [47:0] acc_ff [3];
   logic signed [47:0] acc_in [3];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // memory
   entry_type         mem [MAX_PARTICLES];
   entry_type         rd_ff;
   logic [AW-1:0]     rd_addr;
   logic              mem_we;
   entry_type         wr_entry;

   logic [JW-1:0]     n_eff;
   logic              idx_ok;
   logic              mul_done;
   logic [SW-1:0]     sq_trial;
   logic [VW-1:0]     num_w;
   logic [40:0]       term;
   logic [47:0]       pj [3];
   logic [47:0]       pi_sel [3];

   assign busy     = (state_ff != ST_IDLE);
   assign idx_ok   = JW'(req.particle_index) < JW'(MAX_PARTICLES);
   assign n_eff    = (JW'(count_ff) > JW'(MAX_PARTICLES)) ? JW'(MAX_PARTICLES) : JW'(count_ff);
   assign mul_done = (mul_b_ff == 64'd0);
   assign mem_we   = start && !busy && idx_ok && (req.command == CMD_LOAD);
   assign rd_addr  = (state_ff == ST_IDLE) ? AW'(req.particle_index) : j_ff[AW-1:0];
   assign sq_trial = res_ff + one_ff;
   assign num_w    = VW'({mul_p_ff[112:0], 48'd0});
   assign term     = (q_ff > {1'b0, cap_ff}) ? {1'b0, cap_ff} : q_ff;

   assign wr_entry = '{pos_x: req.pos_x, pos_y: req.pos_y, pos_z: req.pos_z,
                       vel_x: req.vel_x, vel_y: req.vel_y, vel_z: req.vel_z,
                       mass: req.mass};

   assign pj[0] = rd_ff.pos_x;
   assign pj[1] = rd_ff.pos_y;
   assign pj[2] = rd_ff.pos_z;
   assign pi_sel[0] = pix_ff;
   assign pi_sel[1] = piy_ff;
   assign pi_sel[2] = piz_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(req.particle_index)] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   function automatic logic signed [39:0] sat40(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = 48'sh007F_FFFF_FFFF;
      lo = -48'sh0080_0000_0000;
      if (v > hi) return 40'sh7F_FFFF_FFFF;
      else if (v < lo) return 40'sh80_0000_0000;
      else return v[39:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      j_in = j_ff;
      k_in = k_ff;
      idx_in = idx_ff;
      pix_in = pix_ff; piy_in = piy_ff; piz_in = piz_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      mi_in = mi_ff; mj_in = mj_ff;
      d_in = d_ff;
      mag_in = mag_ff;
      s_in = s_ff; op_in = op_ff; res_in = res_ff; one_in = one_ff;
      r_in = r_ff;
      den_in = den_ff;
      gm_in = gm_ff;
      rem_in = rem_ff; dsh_in = dsh_ff; q_in = q_ff; dcnt_in = dcnt_ff;
      acc_in = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      // shift-add multiplier runs whenever operand b is nonzero
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      mul_p_in = mul_p_ff;
      if (!mul_done) begin
         if (mul_b_ff[0]) mul_p_in = mul_p_ff + mul_a_ff;
         mul_a_in = {mul_a_ff[MW-2:0], 1'b0};
         mul_b_in = {1'b0, mul_b_ff[63:1]};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start && idx_ok && req.command == CMD_EVAL) begin
               idx_in = req.particle_index;
               state_in = ST_IRD;
            end
         end
         ST_IRD: begin
            pix_in = rd_ff.pos_x; piy_in = rd_ff.pos_y; piz_in = rd_ff.pos_z;
            vx_in = rd_ff.vel_x; vy_in = rd_ff.vel_y; vz_in = rd_ff.vel_z;
            mi_in = rd_ff.mass;
            j_in = '0;
            for (int a = 0; a < 3; a++) acc_in[a] = '0;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (j_ff >= n_eff) begin
               rsp_in.result_index = idx_ff;
               rsp_in.rate_x = vx_ff;
               rsp_in.rate_y = vy_ff;
               rsp_in.rate_z = vz_ff;
               rsp_in.force_x = sat40(acc_ff[0]);
               rsp_in.force_y = sat40(acc_ff[1]);
               rsp_in.force_z = sat40(acc_ff[2]);
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (j_ff == JW'(idx_ff)) begin
               j_in = j_ff + JW'(1);
            end else begin
               state_in = ST_JRD;
            end
         end
         ST_JRD: begin
            for (int a = 0; a < 3; a++) begin
               d_in[a] = {pj[a][47], pj[a]} - {pi_sel[a][47], pi_sel[a]};
               mag_in[a] = d_in[a][48] ? (~d_in[a] + 49'd1) : d_in[a];
            end
            mj_in = rd_ff.mass;
            s_in = '0;
            k_in = 2'd0;
            mul_a_in = MW'(mag_in[0]);
            mul_b_in = 64'(mag_in[0]);
            mul_p_in = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (mul_done) begin
               s_in = s_ff + mul_p_ff[SW-1:0];
               if (k_ff == 2'd2) begin
                  op_in = s_in;
                  res_in = '0;
                  one_in = SW'(1) << (SW - 2);
                  state_in = ST_SQRT;
               end else begin
                  k_in = k_ff + 2'd1;
                  mul_a_in = MW'(mag_ff[k_in]);
                  mul_b_in = 64'(mag_ff[k_in]);
                  mul_p_in = '0;
               end
            end
         end
         ST_SQRT: begin
            if (one_ff == '0) begin
               r_in = res_ff[49:0];
               mul_a_in = MW'(res_ff[49:0]);
               mul_b_in = 64'(res_ff[49:0]);
               mul_p_in = '0;
               state_in = ST_R2;
            end else begin
               if (op_ff >= sq_trial) begin
                  op_in = op_ff - sq_trial;
                  res_in = (res_ff >> 1) + one_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               one_in = one_ff >> 2;
            end
         end
         ST_R2: begin
            if (mul_done) begin
               mul_a_in = MW'(mul_p_ff[99:0]);
               mul_b_in = 64'(r_ff);
               mul_p_in = '0;
               state_in = ST_R3;
            end
         end
         ST_R3: begin
            if (mul_done) begin
               den_in = mul_p_ff[DW-1:0] + DW'({soft_ff, 48'd0});
               mul_a_in = MW'(mi_ff);
               mul_b_in = 64'(mj_ff);
               mul_p_in = '0;
               state_in = ST_MM;
            end
         end
         ST_MM: begin
            if (mul_done) begin
               mul_a_in = MW'(mul_p_ff[31:0]);
               mul_b_in = 64'(grav_ff);
               mul_p_in = '0;
               state_in = ST_GM;
            end
         end
         ST_GM: begin
            if (mul_done) begin
               gm_in = mul_p_ff[63:0];
               k_in = 2'd0;
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            // zero difference or zero denominator: the term is zero
            if (mag_ff[k_ff] == '0 || den_ff == '0) begin
               if (k_ff == 2'd2) begin
                  j_in = j_ff + JW'(1);
                  state_in = ST_NEXT;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               mul_a_in = MW'(gm_ff);
               mul_b_in = 64'(mag_ff[k_ff]);
               mul_p_in = '0;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            if (mul_done) begin
               if (num_w >= VW'({den_ff, 41'd0})) begin
                  q_in = {1'b0, cap_ff};
                  state_in = ST_TERM;
               end else begin
                  rem_in = num_w;
                  dsh_in = VW'({den_ff, 40'd0});
                  q_in = '0;
                  dcnt_in = 6'd41;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in = {q_ff[39:0], 1'b1};
            end else begin
               q_in = {q_ff[39:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            dcnt_in = dcnt_ff - 6'd1;
            if (dcnt_ff == 6'd1) state_in = ST_TERM;
         end
         ST_TERM: begin
            acc_in[k_ff] = d_ff[k_ff][48] ? acc_ff[k_ff] - 48'(term)
                                          : acc_ff[k_ff] + 48'(term);
            if (k_ff == 2'd2) begin
               j_in = j_ff + JW'(1);
               state_in = ST_NEXT;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = ST_AXIS;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_b_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_b_ff     <= mul_b_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in;
      k_ff <= k_in;
      idx_ff <= idx_in;
      pix_ff <= pix_in; piy_ff <= piy_in; piz_ff <= piz_in;
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
      mi_ff <= mi_in; mj_ff <= mj_in;
      d_ff <= d_in;
      mag_ff <= mag_in;
      s_ff <= s_in; op_ff <= op_in; res_ff <= res_in; one_ff <= one_in;
      r_ff <= r_in;
      den_ff <= den_in;
      gm_ff <= gm_in;
      mul_a_ff <= mul_a_in;
      mul_p_ff <= mul_p_in;
      rem_ff <= rem_in; dsh_ff <= dsh_in; q_ff <= q_in; dcnt_ff <= dcnt_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // a result strobe follows the end of an evaluation, which returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe outside idle");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && idx_ok && req.command == CMD_EVAL) |=> busy)
      else $error("evaluate transfer did not start the walk");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dcnt_ff != 6'd0)
      else $error("divider ran past its last quotient bit");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !busy)
      else $error("memory write during evaluation");

endmodule
